// ----- hw/rtl/gbd_pkg.sv -----
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and constants of the Gaussian reduce (blur, decimate by two).
// ----------------------------------------------------------------------------
`default_nettype none

package gbd_pkg;

    localparam int OUT_SAMPLE_BITS = 16;
    localparam int OUT_POS_BITS    = 10;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CHANNELS        = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_VALUE     = 2'd3;

    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;
    localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd3;
    localparam logic [15:0] RST_MAX_VALUE     = 16'd255;

    // Per-pixel control that travels with the pipeline.
    typedef struct packed {
        logic                    emit;   // pixel completes an output window
        logic                    done;   // last result of the frame
        logic                    vtop;   // top mirror: rows r, r-1, r-2, r-1, r
        logic                    vbot;   // bottom mirror: rows r-3 .. r, r
        logic                    hleft;  // left mirror on columns
        logic                    hright; // right mirror on columns
        logic [OUT_POS_BITS-1:0] ox;
        logic [OUT_POS_BITS-1:0] oy;
    } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gbd_ram.sv -----
// ----------------------------------------------------------------------------
// gbd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbd_ctrl
// Raster position counters and per-pixel window/mirror decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [11:0]                   frame_width,
    input  wire logic [11:0]                   frame_height,
    output gbd_pkg::ctl_t                      ctl,
    output logic      [$clog2(MAX_WIDTH)-1:0]  col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1) + 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1) + 1;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] c_ext;
    logic [HW-1:0] r_ext;
    logic          row_normal;
    logic          row_bot;
    logic          col_normal;
    logic          col_right;
    logic          row_in;
    logic          col_in;
    logic [31:0]   ox_full;
    logic [31:0]   oy_full;

    always_comb
    begin
        if (frame_width < 12'd3)
            w_eff = WW'(3);
        else if (32'(frame_width) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width);

        if (frame_height < 12'd3)
            h_eff = HW'(3);
        else if (32'(frame_height) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height);
    end

    assign c_ext = WW'(col_reg);
    assign r_ext = HW'(row_reg);

    assign row_in     = r_ext <= (h_eff - HW'(1));
    assign col_in     = c_ext <= (w_eff - WW'(1));
    assign row_normal = (r_ext >= HW'(2)) && !row_reg[0];
    assign row_bot    = !row_normal && (r_ext == h_eff - HW'(1)) && !h_eff[0];
    assign col_normal = (c_ext >= WW'(2)) && !col_reg[0];
    assign col_right  = !col_normal && (c_ext == w_eff - WW'(1)) && !w_eff[0];

    assign ox_full = 32'(col_reg >> 1) - (col_normal ? 32'd1 : 32'd0);
    assign oy_full = 32'(row_reg >> 1) - (row_normal ? 32'd1 : 32'd0);

    always_comb
    begin
        ctl.emit   = row_in && col_in && (row_normal || row_bot) && (col_normal || col_right);
        ctl.done   = (r_ext == h_eff - HW'(1)) && (c_ext == w_eff - WW'(1));
        ctl.vtop   = r_ext == HW'(2);
        ctl.vbot   = row_bot;
        ctl.hleft  = c_ext == WW'(2);
        ctl.hright = col_right;
        ctl.ox     = ox_full[gbd_pkg::OUT_POS_BITS-1:0];
        ctl.oy     = oy_full[gbd_pkg::OUT_POS_BITS-1:0];
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (c_ext + WW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (r_ext + HW'(1) >= h_eff) ? '0 : RW'(r_ext + HW'(1));
        end
        else
        begin
            col_next = CW'(c_ext + WW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gbd_lane.sv -----
// ----------------------------------------------------------------------------
// gbd_lane
// One channel: vertical 1-4-6-4-1 sum, column shift line, horizontal sum,
// rounding and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_lane #(
    parameter int SB = 16
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [SB-1:0]       d0,
    input  wire logic [4*SB-1:0]     hist,
    input  wire gbd_pkg::ctl_t       ctl_b,
    input  wire logic                vld_c,
    input  wire gbd_pkg::ctl_t       ctl_d,
    input  wire logic [SB-1:0]       limit,
    output logic      [SB-1:0]       res
);

    localparam int VW = SB + 4;
    localparam int SW = SB + 9;

    logic [SB-1:0] d1, d2, d3, d4;
    logic [SB-1:0] t0, t1, t2, t3, t4;
    logic [VW-1:0] vsum;
    logic [VW-1:0] v_c_reg;
    logic [VW-1:0] h_reg [5];
    logic [VW-1:0] u0, u1, u2, u3, u4;
    logic [SW-1:0] hsum;
    logic [SW-1:0] rnd;

    assign d1 = hist[SB-1:0];
    assign d2 = hist[2*SB-1:SB];
    assign d3 = hist[3*SB-1:2*SB];
    assign d4 = hist[4*SB-1:3*SB];

    always_comb
    begin
        if (ctl_b.vtop)
        begin
            t0 = d0; t1 = d1; t2 = d2; t3 = d1; t4 = d0;
        end
        else if (ctl_b.vbot)
        begin
            t0 = d3; t1 = d2; t2 = d1; t3 = d0; t4 = d0;
        end
        else
        begin
            t0 = d4; t1 = d3; t2 = d2; t3 = d1; t4 = d0;
        end
        vsum = VW'(t0) + VW'(t4) + (VW'(VW'(t1) + VW'(t3)) << 2)
             + (VW'(t2) << 2) + (VW'(t2) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_c_reg <= vsum;
        end
        if (en && vld_c)
        begin
            h_reg[0] <= v_c_reg;
            h_reg[1] <= h_reg[0];
            h_reg[2] <= h_reg[1];
            h_reg[3] <= h_reg[2];
            h_reg[4] <= h_reg[3];
        end
    end

    // h_reg[0] holds the newest column
    always_comb
    begin
        if (ctl_d.hleft)
        begin
            u0 = h_reg[0]; u1 = h_reg[1]; u2 = h_reg[2]; u3 = h_reg[1]; u4 = h_reg[0];
        end
        else if (ctl_d.hright)
        begin
            u0 = h_reg[3]; u1 = h_reg[2]; u2 = h_reg[1]; u3 = h_reg[0]; u4 = h_reg[0];
        end
        else
        begin
            u0 = h_reg[4]; u1 = h_reg[3]; u2 = h_reg[2]; u3 = h_reg[1]; u4 = h_reg[0];
        end
        hsum = SW'(u0) + SW'(u4) + (SW'(SW'(u1) + SW'(u3)) << 2)
             + (SW'(u2) << 2) + (SW'(u2) << 1);
        rnd  = (hsum + SW'(128)) >> 8;
        res  = (rnd > SW'(limit)) ? limit : rnd[SB-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gauss_blur_decimate_by_two_unit.sv -----
// ----------------------------------------------------------------------------
// gauss_blur_decimate_by_two_unit
// 5x5 binomial blur with mirrored borders and 2:1 decimation in both axes.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the skid slot holds no result; one result
//   per window-completing pixel. A pixel that completes its window passes line
//   store read, vertical sum, column shift and horizontal sum with round and
//   clamp into the output register, which drives m_tdata.
// Reset: position counters clear and config returns to 640x480, 3 channels,
//   max 255; the line store is not cleared (it is always written before use).
`default_nettype none

module gauss_blur_decimate_by_two_unit #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int LANES       = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample_a, sample_b, sample_c
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // out_a, out_b, out_c, out_col, out_row, zero pad
    output logic             m_tlast,   // frame_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [gbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [gbd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NL = (LANES > gbd_pkg::CHANNELS) ? gbd_pkg::CHANNELS : LANES;
    localparam int SB = SAMPLE_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RWD = NL * 4 * SB;
    localparam int OW = 3 * gbd_pkg::OUT_SAMPLE_BITS + 2 * gbd_pkg::OUT_POS_BITS + 1;

    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [1:0]  channel_count_reg;
    logic [15:0] max_value_reg;

    logic          en;
    logic          accept;
    gbd_pkg::ctl_t ctl_a;
    logic [CW-1:0] col_a;

    logic          vld_b_reg;
    gbd_pkg::ctl_t ctl_b_reg;
    logic [CW-1:0] col_b_reg;
    logic [NL*SB-1:0] d0_b_reg;
    logic          vld_c_reg;
    gbd_pkg::ctl_t ctl_c_reg;
    logic          vld_d_reg;
    gbd_pkg::ctl_t ctl_d_reg;

    logic [RWD-1:0] hist;
    logic [RWD-1:0] wdata;
    logic [SB-1:0]  limit;
    logic [1:0]     lanes_eff;
    logic [SB-1:0]  lane_res [NL];
    logic [gbd_pkg::OUT_SAMPLE_BITS-1:0] ch_out [gbd_pkg::CHANNELS];
    logic [OW-1:0]  res_word;
    logic           res_go;

    logic           out_vld_reg;
    logic [OW-1:0]  out_reg;
    logic           skid_vld_reg;
    logic [OW-1:0]  skid_reg;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= gbd_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= gbd_pkg::RST_FRAME_HEIGHT;
            channel_count_reg <= gbd_pkg::RST_CHANNEL_COUNT;
            max_value_reg     <= gbd_pkg::RST_MAX_VALUE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gbd_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[11:0];
                gbd_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[11:0];
                gbd_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                gbd_pkg::CFG_MAX_VALUE:     max_value_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the skid slot is holding a result.
    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    gbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .ctl          (ctl_a),
        .col          (col_a)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_b_reg <= accept;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_b_reg <= ctl_a;
            col_b_reg <= col_a;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
            for (int k = 0; k < NL; k++)
            begin
                d0_b_reg[k*SB +: SB] <= s_tdata[k*gbd_pkg::OUT_SAMPLE_BITS +: SB];
            end
        end
    end

    // Line store: per column, the four previous rows of every lane.
    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            wdata[k*4*SB +: 4*SB] = {hist[k*4*SB +: 3*SB], d0_b_reg[k*SB +: SB]};
        end
    end

    gbd_ram #(
        .WIDTH (RWD),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (en && vld_b_reg),
        .waddr (col_b_reg),
        .wdata (wdata),
        .re    (en),
        .raddr (col_a),
        .rdata (hist)
    );

    assign limit = (32'(max_value_reg) > ((1 << SB) - 1)) ? SB'((1 << SB) - 1)
                                                          : SB'(max_value_reg);
    assign lanes_eff = (channel_count_reg == 2'd0) ? 2'd1 : channel_count_reg;

    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        gbd_lane #(
            .SB (SB)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .d0    (d0_b_reg[k*SB +: SB]),
            .hist  (hist[k*4*SB +: 4*SB]),
            .ctl_b (ctl_b_reg),
            .vld_c (vld_c_reg),
            .ctl_d (ctl_d_reg),
            .limit (limit),
            .res   (lane_res[k])
        );
    end

    // Merge lanes into one result word
    always_comb
    begin
        for (int k = 0; k < gbd_pkg::CHANNELS; k++)
        begin
            ch_out[k] = '0;
            if (k < NL)
            begin
                if (2'(k) < lanes_eff)
                    ch_out[k] = gbd_pkg::OUT_SAMPLE_BITS'(lane_res[k % NL]);
            end
        end
        res_word = {ctl_d_reg.done, ctl_d_reg.oy, ctl_d_reg.ox, ch_out[2], ch_out[1], ch_out[0]};
    end

    assign res_go = en && vld_d_reg && ctl_d_reg.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (m_tready)
                skid_vld_reg <= 1'b0;
        end
        else if (res_go)
        begin
            if (!out_vld_reg || m_tready)
                out_vld_reg <= 1'b1;
            else
                skid_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (res_go)
        begin
            if (!out_vld_reg || m_tready)
                out_reg <= res_word;
            else
                skid_reg <= res_word;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_reg[OW-2:0]};
    assign m_tlast  = out_reg[OW-1];

endmodule

`default_nettype wire

// ----- verif/gauss_blur_decimate_by_two_unit_tb.sv -----
// ----------------------------------------------------------------------------
// gauss_blur_decimate_by_two_unit_tb
// Streams whole frames through the Gaussian reduce block. The frames run under
// many size, channel and clamp settings, and under random source gaps and
// sink stalls. Each result is checked against an in-bench 5x5 binomial
// filter with mirrored borders.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gauss_blur_decimate_by_two_unit_tb;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
    } pyr_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [gbd_pkg::CFG_INDEX_BITS-1:0] cfg_index = gbd_pkg::CFG_FRAME_WIDTH;
    logic [gbd_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    gauss_blur_decimate_by_two_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // shadow of the block's registers and line buffer
    logic [11:0] sh_width  = gbd_pkg::RST_FRAME_WIDTH;
    logic [11:0] sh_height = gbd_pkg::RST_FRAME_HEIGHT;
    logic [1:0]  sh_chans  = gbd_pkg::RST_CHANNEL_COUNT;
    logic [15:0] sh_maxval = gbd_pkg::RST_MAX_VALUE;
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    logic [15:0] row_ring [5][2048][3];

    logic [47:0] pixel_q [$];
    pyr_pixel_t  reduced_q [$];
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          n_errors = 0;
    int          n_items = 0;

    function automatic int unsigned fold_index(int p, int n);
        if (p < 0) p = -p;
        if (p >= n) p = 2 * n - p - 1;
        return p;
    endfunction

    function automatic int unsigned blur_sample(int cy, int cx, int lane, int w, int h,
                                                int unsigned limit);
        int unsigned sum;
        int unsigned wt [5];
        int unsigned yi;
        int unsigned xj;
        sum = 0;
        wt = '{1, 4, 6, 4, 1};
        for (int i = -2; i <= 2; i++)
        begin
            yi = fold_index(cy + i, h);
            for (int j = -2; j <= 2; j++)
            begin
                xj = fold_index(cx + j, w);
                sum += 32'(row_ring[yi % 5][xj][lane]) * wt[i + 2] * wt[j + 2];
            end
        end
        sum = (sum + 128) >> 8;
        return (sum > limit) ? limit : sum;
    endfunction

    task automatic reduce_pixel(input logic [47:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned lanes;
        int unsigned r;
        int unsigned c;
        int unsigned oy;
        int unsigned ox;
        bit          row_hit;
        bit          col_hit;
        pyr_pixel_t  res;
        w = (sh_width < 3) ? 3 : (sh_width > 2048) ? 2048 : 32'(sh_width);
        h = (sh_height < 3) ? 3 : (sh_height > 2048) ? 2048 : 32'(sh_height);
        lanes = (sh_chans == 0) ? 1 : 32'(sh_chans);
        r = cur_row;
        c = cur_col;
        oy = 0;
        ox = 0;
        row_hit = 0;
        col_hit = 0;
        for (int k = 0; k < 3; k++)
            row_ring[r % 5][c][k] = px[16*k +: 16];
        if (r >= 2 && r[0] == 1'b0)
        begin
            row_hit = 1;
            oy = r / 2 - 1;
        end
        else if (r == h - 1 && h[0] == 1'b0)
        begin
            row_hit = 1;
            oy = h / 2 - 1;
        end
        if (c >= 2 && c[0] == 1'b0)
        begin
            col_hit = 1;
            ox = c / 2 - 1;
        end
        else if (c == w - 1 && w[0] == 1'b0)
        begin
            col_hit = 1;
            ox = w / 2 - 1;
        end
        if (row_hit && col_hit)
        begin
            res.a = 16'(blur_sample(2 * oy, 2 * ox, 0, w, h, 32'(sh_maxval)));
            res.b = (lanes > 1) ? 16'(blur_sample(2 * oy, 2 * ox, 1, w, h, 32'(sh_maxval)))
                                : 16'd0;
            res.c = (lanes > 2) ? 16'(blur_sample(2 * oy, 2 * ox, 2, w, h, 32'(sh_maxval)))
                                : 16'd0;
            res.col = ox[9:0];
            res.row = oy[9:0];
            res.last = (r == h - 1 && c == w - 1);
            reduced_q.push_back(res);
        end
        if (c + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endtask

    // source side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                reduce_pixel(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                pyr_pixel_t want;
                if (reduced_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want = reduced_q.pop_front();
                    if (m_tdata[15:0] !== want.a || m_tdata[31:16] !== want.b ||
                        m_tdata[47:32] !== want.c || m_tdata[57:48] !== want.col ||
                        m_tdata[67:58] !== want.row || m_tlast !== want.last)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display(
                                "mismatch exp %h %h %h r%0d c%0d %b got %h %h %h r%0d c%0d %b",
                                want.a, want.b, want.c, want.row, want.col, want.last,
                                m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                m_tdata[67:58], m_tdata[57:48], m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic write_reg(input logic [gbd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            gbd_pkg::CFG_FRAME_WIDTH:   sh_width  = val[11:0];
            gbd_pkg::CFG_FRAME_HEIGHT:  sh_height = val[11:0];
            gbd_pkg::CFG_CHANNEL_COUNT: sh_chans  = val[1:0];
            gbd_pkg::CFG_MAX_VALUE:     sh_maxval = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_tvalid || reduced_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // mode: 0 plain random, 1 all ones, 2 all zeros, 3 all ones on every third pixel, else zeros
    task automatic run_frame(input int unsigned w, input int unsigned h, input int chans,
                             input logic [15:0] maxval, input int mode, input int phase);
        case (phase % 5)
            0:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct = 70;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 70;
            end
            3:
            begin
                src_idle_pct = 24;
                snk_stall_pct = 24;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
        endcase
        wait_drained();
        write_reg(gbd_pkg::CFG_FRAME_WIDTH, {4'($urandom_range(15)), 12'(w)});
        write_reg(gbd_pkg::CFG_FRAME_HEIGHT, {4'($urandom_range(15)), 12'(h)});
        write_reg(gbd_pkg::CFG_CHANNEL_COUNT, {14'($urandom), 2'(chans)});
        write_reg(gbd_pkg::CFG_MAX_VALUE, maxval);
        w = (w < 3) ? 3 : (w > 2048) ? 2048 : w;
        h = (h < 3) ? 3 : (h > 2048) ? 2048 : h;
        for (int i = 0; i < w * h; i++)
        begin
            case (mode)
                1: pixel_q.push_back({48{1'b1}});
                2: pixel_q.push_back('0);
                3: pixel_q.push_back((i % 3 == 0) ? {48{1'b1}} : 48'h0);
                default: pixel_q.push_back({16'($urandom), 16'($urandom), 16'($urandom)});
            endcase
        end
        n_items += w * h;
    endtask

    initial
    begin
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        ph = 0;
        // directed: clamp extremes, tiny frames, size clamping, channel counts
        run_frame(5, 5, 3, 16'hFFFF, 1, ph++);
        run_frame(3, 3, 3, 16'h0000, 0, ph++);
        run_frame(4, 4, 3, 16'h0001, 3, ph++);
        run_frame(6, 3, 0, 16'hFFFF, 0, ph++);
        run_frame(3, 4, 1, 16'hFFFF, 2, ph++);
        run_frame(7, 6, 2, 16'h8000, 0, ph++);
        run_frame(0, 1, 3, 16'hFFFF, 0, ph++);
        run_frame(5, 0, 3, 16'hFFFF, 0, ph++);
        run_frame(2, 7, 2, 16'h00FF, 0, ph++);
        while (n_items < 2000)
        begin
            logic [15:0] mv;
            mv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF;
            run_frame($urandom_range(3, 14), $urandom_range(3, 12), $urandom_range(3),
                      mv, ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0, ph++);
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (n_errors == 0 && reduced_q.size() == 0)
            $display("gauss_blur_decimate_by_two_unit test passed");
        else
            $display("gauss_blur_decimate_by_two_unit test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("gauss_blur_decimate_by_two_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
